// ===== sv/dbd_pkg.sv =====
// ----------------------------------------------------------------------------
// dbd_pkg
// Shared types and constants for the detection box decode block.
// ----------------------------------------------------------------------------
package dbd_pkg;

  // Class counter saturates at MAX_CLASSES-1 (class_id is 8 bits wide).
  localparam int unsigned MAX_CLASSES = 256;
  localparam int unsigned CLS_W       = 8;

  // Queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned CFG_DATA_W  = 24;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIG_WIDTH     = 3'd0,
    CFG_ORIG_HEIGHT    = 3'd1,
    CFG_PAD_X          = 3'd2,
    CFG_PAD_Y          = 3'd3,
    CFG_INV_SCALE      = 3'd4,
    CFG_CONF_THRESHOLD = 3'd5
  } cfg_idx_t;

  localparam logic [12:0] RST_ORIG_WIDTH     = 13'd640;
  localparam logic [12:0] RST_ORIG_HEIGHT    = 13'd480;
  localparam logic [10:0] RST_PAD_X          = 11'd0;
  localparam logic [10:0] RST_PAD_Y          = 11'd80;
  localparam logic [23:0] RST_INV_SCALE      = 24'd65536;
  localparam logic [15:0] RST_CONF_THRESHOLD = 16'd16384;

  // Register file contents.
  typedef struct packed {
    logic [12:0] orig_width;
    logic [12:0] orig_height;
    logic [10:0] pad_x;
    logic [10:0] pad_y;
    logic [23:0] inv_scale;
    logic [15:0] conf_threshold;
  } cfg_t;

  // One kept prediction handed from front to back.
  typedef struct packed {
    logic [15:0]      center_x;
    logic [15:0]      center_y;
    logic [15:0]      box_w;
    logic [15:0]      box_h;
    logic [15:0]      conf;
    logic [CLS_W-1:0] cls;
    logic [15:0]      pidx;
  } det_t;

  // Queue status seen by the neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== sv/detection_box_decode_core.sv =====
// ----------------------------------------------------------------------------
// detection_box_decode_core
// Streams per-class scores, keeps the best class per prediction and emits
// the decoded, letterbox-corrected and clamped box of kept predictions.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------------
//  in_     | sink      | in_valid / in_stall | one class score + box fields
//  out_    | source    | out_valid/out_stall | one decoded box
//  cfg_    | sink      | cfg_we              | register index + data
//
//  One score word per cycle while in_stall is low; the running max is a single 16-bit compare.
//  A kept box passes the box queue, the back pipeline and its output register.
//  in_stall rises only when the 4-entry box queue is full, i.e. when the
//  output has been stalled long enough to back the pipe up.
//  Reset is synchronous (rst_n low); registers return to their defaults.
//
module detection_box_decode_core #(
  parameter int unsigned MAX_CLASSES = dbd_pkg::MAX_CLASSES
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // score stream
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [15:0]                        in_center_x,
  input  logic [15:0]                        in_center_y,
  input  logic [15:0]                        in_box_w,
  input  logic [15:0]                        in_box_h,
  input  logic [15:0]                        in_class_score,
  input  logic                               in_last_class,
  input  logic [15:0]                        in_pred_index,
  // box stream
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [11:0]                        out_box_x,
  output logic [11:0]                        out_box_y,
  output logic [12:0]                        out_box_width,
  output logic [12:0]                        out_box_height,
  output logic [7:0]                         out_class_id,
  output logic [15:0]                        out_confidence,
  output logic [15:0]                        out_source_index,
  // register writes
  input  logic                               cfg_we,
  input  logic [dbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbd_pkg::CFG_DATA_W-1:0]     cfg_data
);

  dbd_pkg::cfg_t    cfg_r, cfg_nxt;
  dbd_pkg::q_stat_t q_stat;
  dbd_pkg::det_t    push_det, pop_det;
  logic             in_acc;
  logic             push, pop;

  // Register file; unknown indexes are dropped.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (dbd_pkg::cfg_idx_t'(cfg_index))
        dbd_pkg::CFG_ORIG_WIDTH:     cfg_nxt.orig_width     = cfg_data[12:0];
        dbd_pkg::CFG_ORIG_HEIGHT:    cfg_nxt.orig_height    = cfg_data[12:0];
        dbd_pkg::CFG_PAD_X:          cfg_nxt.pad_x          = cfg_data[10:0];
        dbd_pkg::CFG_PAD_Y:          cfg_nxt.pad_y          = cfg_data[10:0];
        dbd_pkg::CFG_INV_SCALE:      cfg_nxt.inv_scale      = cfg_data[23:0];
        dbd_pkg::CFG_CONF_THRESHOLD: cfg_nxt.conf_threshold = cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.orig_width     <= dbd_pkg::RST_ORIG_WIDTH;
      cfg_r.orig_height    <= dbd_pkg::RST_ORIG_HEIGHT;
      cfg_r.pad_x          <= dbd_pkg::RST_PAD_X;
      cfg_r.pad_y          <= dbd_pkg::RST_PAD_Y;
      cfg_r.inv_scale      <= dbd_pkg::RST_INV_SCALE;
      cfg_r.conf_threshold <= dbd_pkg::RST_CONF_THRESHOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // input side stalls only on a full queue
  assign in_stall = q_stat.full;
  assign in_acc   = in_valid && !in_stall;

  dbd_front #(
    .MAX_CLASSES (MAX_CLASSES)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .acc            (in_acc),
    .center_x       (in_center_x),
    .center_y       (in_center_y),
    .box_w          (in_box_w),
    .box_h          (in_box_h),
    .class_score    (in_class_score),
    .last_class     (in_last_class),
    .pred_index     (in_pred_index),
    .conf_threshold (cfg_r.conf_threshold),
    .push           (push),
    .push_det       (push_det)
  );

  dbd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_det (push_det),
    .pop      (pop),
    .pop_det  (pop_det),
    .stat     (q_stat)
  );

  dbd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .q_stat           (q_stat),
    .q_det            (pop_det),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_box_x        (out_box_x),
    .out_box_y        (out_box_y),
    .out_box_width    (out_box_width),
    .out_box_height   (out_box_height),
    .out_class_id     (out_class_id),
    .out_confidence   (out_confidence),
    .out_source_index (out_source_index)
  );

endmodule

// ===== sv/dbd_front.sv =====
// ----------------------------------------------------------------------------
// dbd_front
// Running class maximum and confidence gate; pushes kept predictions.
// ----------------------------------------------------------------------------
module dbd_front #(
  parameter int unsigned MAX_CLASSES = dbd_pkg::MAX_CLASSES
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  logic [15:0]           center_x,
  input  logic [15:0]           center_y,
  input  logic [15:0]           box_w,
  input  logic [15:0]           box_h,
  input  logic [15:0]           class_score,
  input  logic                  last_class,
  input  logic [15:0]           pred_index,
  input  logic [15:0]           conf_threshold,
  output logic                  push,
  output dbd_pkg::det_t         push_det
);

  localparam logic [dbd_pkg::CLS_W-1:0] POS_MAX = dbd_pkg::CLS_W'(MAX_CLASSES - 1);

  logic [15:0]               best_score_r, best_score_nxt;
  logic [dbd_pkg::CLS_W-1:0] best_class_r, best_class_nxt;
  logic [dbd_pkg::CLS_W-1:0] class_pos_r,  class_pos_nxt;
  logic [15:0]               run_score;
  logic [dbd_pkg::CLS_W-1:0] run_class;

  // strict greater: first index wins ties
  always_comb begin
    if (class_score > best_score_r) begin
      run_score = class_score;
      run_class = class_pos_r;
    end else begin
      run_score = best_score_r;
      run_class = best_class_r;
    end
  end

  always_comb begin
    best_score_nxt = best_score_r;
    best_class_nxt = best_class_r;
    class_pos_nxt  = class_pos_r;
    if (acc) begin
      if (last_class) begin
        best_score_nxt = '0;
        best_class_nxt = '0;
        class_pos_nxt  = '0;
      end else begin
        best_score_nxt = run_score;
        best_class_nxt = run_class;
        if (class_pos_r < POS_MAX) begin
          class_pos_nxt = class_pos_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_score_r <= '0;
      best_class_r <= '0;
      class_pos_r  <= '0;
    end else begin
      best_score_r <= best_score_nxt;
      best_class_r <= best_class_nxt;
      class_pos_r  <= class_pos_nxt;
    end
  end

  assign push = acc && last_class && (run_score >= conf_threshold);

  always_comb begin
    push_det.center_x = center_x;
    push_det.center_y = center_y;
    push_det.box_w    = box_w;
    push_det.box_h    = box_h;
    push_det.conf     = run_score;
    push_det.cls      = run_class;
    push_det.pidx     = pred_index;
  end

endmodule

// ===== sv/dbd_queue.sv =====
// ----------------------------------------------------------------------------
// dbd_queue
// Small register queue between front and back.
// ----------------------------------------------------------------------------
module dbd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  dbd_pkg::det_t     push_det,
  input  logic              pop,
  output dbd_pkg::det_t     pop_det,
  output dbd_pkg::q_stat_t  stat
);

  localparam int unsigned PTR_W = (dbd_pkg::QUEUE_DEPTH > 1) ? $clog2(dbd_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(dbd_pkg::QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(dbd_pkg::QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(dbd_pkg::QUEUE_DEPTH - 1);

  dbd_pkg::det_t      mem_r [dbd_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r,  count_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (count_r == DEPTH_C);
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_det    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_det;
    end
  end

endmodule

// ===== sv/dbd_back.sv =====
// ----------------------------------------------------------------------------
// dbd_back
// Letterbox removal, inverse scaling, clamping and the output register.
// ----------------------------------------------------------------------------
module dbd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  dbd_pkg::cfg_t     cfg,
  input  dbd_pkg::q_stat_t  q_stat,
  input  dbd_pkg::det_t     q_det,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [11:0]       out_box_x,
  output logic [11:0]       out_box_y,
  output logic [12:0]       out_box_width,
  output logic [12:0]       out_box_height,
  output logic [7:0]        out_class_id,
  output logic [15:0]       out_confidence,
  output logic [15:0]       out_source_index
);

  typedef struct packed {
    logic [15:0] conf;
    logic [7:0]  cls;
    logic [15:0] pidx;
  } meta_t;

  logic adv;

  // stage 1: left / top edge in Q.6
  logic               s1_v_r;
  logic signed [18:0] s1_lx_r, s1_ly_r;
  logic [15:0]        s1_bw_r, s1_bh_r;
  meta_t              s1_meta_r;

  // stage 2: products
  logic               s2_v_r;
  logic signed [43:0] s2_px_r, s2_py_r;
  logic [39:0]        s2_pw_r, s2_ph_r;
  meta_t              s2_meta_r;

  // stage 3: truncated and low-side clamped
  logic               s3_v_r;
  logic signed [22:0] s3_x_r, s3_y_r, s3_w_r, s3_h_r;
  meta_t              s3_meta_r;

  logic               out_valid_r;
  logic [11:0]        box_x_r, box_y_r;
  logic [12:0]        box_w_r, box_h_r;
  meta_t              out_meta_r;

  logic signed [18:0] lx_nxt, ly_nxt;
  logic signed [43:0] px_nxt, py_nxt;
  logic signed [24:0] scale_s;
  logic signed [43:0] px_rnd, py_rnd;
  logic signed [22:0] xt, yt, wt, ht;
  logic signed [22:0] x1_nxt, y1_nxt, w1_nxt, h1_nxt;
  logic signed [22:0] lim_w, lim_h;
  logic signed [22:0] x2, y2, w2, h2, w3, h3;
  logic               emit;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_stat.empty;

  // 2*cx - bw - 64*pad
  assign lx_nxt = $signed({2'b00, q_det.center_x, 1'b0}) - $signed({3'b000, q_det.box_w})
                - $signed({2'b00, cfg.pad_x, 6'b0});
  assign ly_nxt = $signed({2'b00, q_det.center_y, 1'b0}) - $signed({3'b000, q_det.box_h})
                - $signed({2'b00, cfg.pad_y, 6'b0});

  assign scale_s = $signed({1'b0, cfg.inv_scale});
  assign px_nxt  = 44'(s1_lx_r) * 44'(scale_s);
  assign py_nxt  = 44'(s1_ly_r) * 44'(scale_s);

  // truncate toward zero: bias negatives before the arithmetic shift
  assign px_rnd = s2_px_r + (s2_px_r[43] ? 44'sd4194303 : 44'sd0);
  assign py_rnd = s2_py_r + (s2_py_r[43] ? 44'sd4194303 : 44'sd0);
  assign xt = {px_rnd[43], px_rnd[43:22]};
  assign yt = {py_rnd[43], py_rnd[43:22]};
  assign wt = {4'b0000, s2_pw_r[39:21]};
  assign ht = {4'b0000, s2_ph_r[39:21]};

  always_comb begin
    x1_nxt = xt;
    w1_nxt = wt;
    y1_nxt = yt;
    h1_nxt = ht;
    if (xt < 0) begin
      w1_nxt = wt + xt;
      x1_nxt = '0;
    end
    if (yt < 0) begin
      h1_nxt = ht + yt;
      y1_nxt = '0;
    end
  end

  // image size saturated to 1..4096
  always_comb begin
    if (cfg.orig_width == '0) begin
      lim_w = 23'sd1;
    end else if (cfg.orig_width > 13'd4096) begin
      lim_w = 23'sd4096;
    end else begin
      lim_w = $signed({10'b0, cfg.orig_width});
    end
    if (cfg.orig_height == '0) begin
      lim_h = 23'sd1;
    end else if (cfg.orig_height > 13'd4096) begin
      lim_h = 23'sd4096;
    end else begin
      lim_h = $signed({10'b0, cfg.orig_height});
    end
  end

  // high-side clamp
  always_comb begin
    x2 = s3_x_r;
    w2 = s3_w_r;
    y2 = s3_y_r;
    h2 = s3_h_r;
    if (s3_x_r >= lim_w) begin
      x2 = lim_w - 23'sd1;
      w2 = 23'sd1;
    end
    if (s3_y_r >= lim_h) begin
      y2 = lim_h - 23'sd1;
      h2 = 23'sd1;
    end
    w3 = ((x2 + w2) > lim_w) ? (lim_w - x2) : w2;
    h3 = ((y2 + h2) > lim_h) ? (lim_h - y2) : h2;
  end

  assign emit = s3_v_r && (w3 > 0) && (h3 > 0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r      <= 1'b0;
      s2_v_r      <= 1'b0;
      s3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_v_r      <= q_pop;
      s2_v_r      <= s1_v_r;
      s3_v_r      <= s2_v_r;
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_lx_r        <= lx_nxt;
      s1_ly_r        <= ly_nxt;
      s1_bw_r        <= q_det.box_w;
      s1_bh_r        <= q_det.box_h;
      s1_meta_r.conf <= q_det.conf;
      s1_meta_r.cls  <= q_det.cls;
      s1_meta_r.pidx <= q_det.pidx;
      s2_px_r        <= px_nxt;
      s2_py_r        <= py_nxt;
      s2_pw_r        <= 40'(s1_bw_r) * 40'(cfg.inv_scale);
      s2_ph_r        <= 40'(s1_bh_r) * 40'(cfg.inv_scale);
      s2_meta_r      <= s1_meta_r;
      s3_x_r         <= x1_nxt;
      s3_y_r         <= y1_nxt;
      s3_w_r         <= w1_nxt;
      s3_h_r         <= h1_nxt;
      s3_meta_r      <= s2_meta_r;
      box_x_r        <= x2[11:0];
      box_y_r        <= y2[11:0];
      box_w_r        <= w3[12:0];
      box_h_r        <= h3[12:0];
      out_meta_r     <= s3_meta_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_box_x        = box_x_r;
  assign out_box_y        = box_y_r;
  assign out_box_width    = box_w_r;
  assign out_box_height   = box_h_r;
  assign out_class_id     = out_meta_r.cls;
  assign out_confidence   = out_meta_r.conf;
  assign out_source_index = out_meta_r.pidx;

endmodule

// ===== sv/dbd_checker.sv =====
// ----------------------------------------------------------------------------
// dbd_checker
// Port-level checks on the box stream, bound to the top level.
// ----------------------------------------------------------------------------
module dbd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_box_x,
  input logic [11:0] out_box_y,
  input logic [12:0] out_box_width,
  input logic [12:0] out_box_height,
  input logic [15:0] out_source_index
);

  // pipe is flushed by reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_word_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_box_x) && $stable(out_box_y) &&
      $stable(out_box_width) && $stable(out_box_height) && $stable(out_source_index))
    else $error("stalled box word changed");

  // clamped size always within 1..4096
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_box_width != 13'd0 && out_box_height != 13'd0 &&
      out_box_width <= 13'd4096 && out_box_height <= 13'd4096)
    else $error("box size out of range");

endmodule

bind detection_box_decode_core dbd_checker u_dbd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_box_x        (out_box_x),
  .out_box_y        (out_box_y),
  .out_box_width    (out_box_width),
  .out_box_height   (out_box_height),
  .out_source_index (out_source_index)
);

// ===== tb/detection_box_decode_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// detection_box_decode_checker
// Watches the score and box channels and the register port of the decode
// core. It keeps its own copy of the registers and of the best-class state,
// predicts each decoded box and compares it field by field with the output.
// ----------------------------------------------------------------------------
module detection_box_decode_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [15:0]                    in_center_x,
  input  logic [15:0]                    in_center_y,
  input  logic [15:0]                    in_box_w,
  input  logic [15:0]                    in_box_h,
  input  logic [15:0]                    in_class_score,
  input  logic                           in_last_class,
  input  logic [15:0]                    in_pred_index,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [11:0]                    out_box_x,
  input  logic [11:0]                    out_box_y,
  input  logic [12:0]                    out_box_width,
  input  logic [12:0]                    out_box_height,
  input  logic [7:0]                     out_class_id,
  input  logic [15:0]                    out_confidence,
  input  logic [15:0]                    out_source_index,
  input  logic                           cfg_we,
  input  logic [dbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dbd_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             boxes_pending,
  output int                             mismatches
);

  // Q.6 left edge times Q8.16 scale -> pixels; Q.5 size times Q8.16 -> pixels
  localparam longint POS_DIV  = 64'sd4194304;
  localparam longint SIZE_DIV = 64'sd2097152;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [12:0] width;
    logic [12:0] height;
    logic [7:0]  cls;
    logic [15:0] conf;
    logic [15:0] src;
  } box_t;

  dbd_pkg::cfg_t regs;
  logic [15:0]   best_score;
  logic [7:0]    best_class;
  logic [7:0]    class_pos;
  box_t          expected_boxes[$];

  function automatic longint sat_dim(input logic [12:0] v);
    if (v == 13'd0) return 1;
    if (v > 13'd4096) return 4096;
    return longint'(v);
  endfunction

  function automatic void clamp_axis(inout longint pos, inout longint len,
                                     input longint lim);
    if (pos < 0) begin
      len = len + pos;
      pos = 0;
    end
    if (pos >= lim) begin
      pos = lim - 1;
      len = 1;
    end
    if (pos + len > lim) len = lim - pos;
  endfunction

  // Geometry of a kept prediction; returns 0 when the box collapses.
  function automatic bit place_box(input logic [15:0] cx, cy, bw, bh,
                                   output box_t box);
    longint s, px, py, pw, ph;
    s  = longint'(regs.inv_scale);
    px = (2 * longint'(cx) - longint'(bw) - 64 * longint'(regs.pad_x)) * s / POS_DIV;
    py = (2 * longint'(cy) - longint'(bh) - 64 * longint'(regs.pad_y)) * s / POS_DIV;
    pw = longint'(bw) * s / SIZE_DIV;
    ph = longint'(bh) * s / SIZE_DIV;
    clamp_axis(px, pw, sat_dim(regs.orig_width));
    clamp_axis(py, ph, sat_dim(regs.orig_height));
    box        = '0;
    box.x      = 12'(px);
    box.y      = 12'(py);
    box.width  = 13'(pw);
    box.height = 13'(ph);
    return (pw > 0) && (ph > 0);
  endfunction

  task automatic report_field(input string name, input logic [15:0] want_v,
                              input logic [15:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s expected %0d got %0d", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin : track
    box_t want;
    if (!rst_n) begin
      regs.orig_width     = dbd_pkg::RST_ORIG_WIDTH;
      regs.orig_height    = dbd_pkg::RST_ORIG_HEIGHT;
      regs.pad_x          = dbd_pkg::RST_PAD_X;
      regs.pad_y          = dbd_pkg::RST_PAD_Y;
      regs.inv_scale      = dbd_pkg::RST_INV_SCALE;
      regs.conf_threshold = dbd_pkg::RST_CONF_THRESHOLD;
      best_score = '0;
      best_class = '0;
      class_pos  = '0;
      expected_boxes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dbd_pkg::CFG_ORIG_WIDTH:     regs.orig_width     = cfg_data[12:0];
          dbd_pkg::CFG_ORIG_HEIGHT:    regs.orig_height    = cfg_data[12:0];
          dbd_pkg::CFG_PAD_X:          regs.pad_x          = cfg_data[10:0];
          dbd_pkg::CFG_PAD_Y:          regs.pad_y          = cfg_data[10:0];
          dbd_pkg::CFG_INV_SCALE:      regs.inv_scale      = cfg_data[23:0];
          dbd_pkg::CFG_CONF_THRESHOLD: regs.conf_threshold = cfg_data[15:0];
          default: ;
        endcase
      end

      if (in_valid && !in_stall) begin
        if (in_class_score > best_score) begin
          best_score = in_class_score;
          best_class = class_pos;
        end
        if (int'(class_pos) < int'(dbd_pkg::MAX_CLASSES) - 1) class_pos = class_pos + 8'd1;
        if (in_last_class) begin
          if (best_score >= regs.conf_threshold &&
              place_box(in_center_x, in_center_y, in_box_w, in_box_h, want)) begin
            want.cls  = best_class;
            want.conf = best_score;
            want.src  = in_pred_index;
            expected_boxes = {expected_boxes, want};
          end
          best_score = '0;
          best_class = '0;
          class_pos  = '0;
        end
      end

      if (out_valid && !out_stall) begin
        if (expected_boxes.size() == 0) begin
          mismatches++;
          $display("%0t: expected no box, got box from source %0d", $time,
                   out_source_index);
        end else begin
          want = expected_boxes.pop_front();
          report_field("box_x", want.x, out_box_x);
          report_field("box_y", want.y, out_box_y);
          report_field("box_width", want.width, out_box_width);
          report_field("box_height", want.height, out_box_height);
          report_field("class_id", want.cls, out_class_id);
          report_field("confidence", want.conf, out_confidence);
          report_field("source_index", want.src, out_source_index);
        end
      end
    end
    boxes_pending <= expected_boxes.size();
  end

endmodule

// ===== tb/detection_box_decode_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// detection_box_decode_core_tb
// Drives score words through the decode core under changing register
// settings and random idling on both channels; the checker beside the core
// predicts every box and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module detection_box_decode_core_tb;

  // Kept boxes pass the queue and the back pipeline; leave room for dropped ones.
  localparam int IDLE_TAIL   = 16;
  // Normal traffic stays well below this limit with no word moving on either
  // channel (register writes, drain waits, stalls).
  localparam int STALL_LIMIT = 2000;
  localparam int SEG_COUNT   = 12;
  localparam int SEG_WORDS   = 120;
  // one prediction longer than the class counter
  localparam int unsigned SAT_WORDS = 300;

  // Indexes past the register file; writes there must be dropped.
  localparam logic [dbd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
  localparam logic [dbd_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

  logic                           clk            = 1'b0;
  logic                           rst_n          = 1'b0;
  logic                           in_valid       = 1'b0;
  logic [15:0]                    in_center_x    = '0;
  logic [15:0]                    in_center_y    = '0;
  logic [15:0]                    in_box_w       = '0;
  logic [15:0]                    in_box_h       = '0;
  logic [15:0]                    in_class_score = '0;
  logic                           in_last_class  = 1'b0;
  logic [15:0]                    in_pred_index  = '0;
  logic                           out_stall      = 1'b0;
  logic                           cfg_we         = 1'b0;
  logic [dbd_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [dbd_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

  logic        in_stall;
  logic        out_valid;
  logic [11:0] out_box_x;
  logic [11:0] out_box_y;
  logic [12:0] out_box_width;
  logic [12:0] out_box_height;
  logic [7:0]  out_class_id;
  logic [15:0] out_confidence;
  logic [15:0] out_source_index;

  int          boxes_pending;
  int          mismatches;
  int          quiet_cycles   = 0;
  int unsigned send_idle_pct  = 9;
  int unsigned recv_stall_pct = 59;
  logic [15:0] cur_threshold  = dbd_pkg::RST_CONF_THRESHOLD;

  detection_box_decode_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_box_w         (in_box_w),
    .in_box_h         (in_box_h),
    .in_class_score   (in_class_score),
    .in_last_class    (in_last_class),
    .in_pred_index    (in_pred_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_box_x        (out_box_x),
    .out_box_y        (out_box_y),
    .out_box_width    (out_box_width),
    .out_box_height   (out_box_height),
    .out_class_id     (out_class_id),
    .out_confidence   (out_confidence),
    .out_source_index (out_source_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  detection_box_decode_checker box_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_box_w         (in_box_w),
    .in_box_h         (in_box_h),
    .in_class_score   (in_class_score),
    .in_last_class    (in_last_class),
    .in_pred_index    (in_pred_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_box_x        (out_box_x),
    .out_box_y        (out_box_y),
    .out_box_width    (out_box_width),
    .out_box_height   (out_box_height),
    .out_class_id     (out_class_id),
    .out_confidence   (out_confidence),
    .out_source_index (out_source_index),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .boxes_pending    (boxes_pending),
    .mismatches       (mismatches)
  );

  always #5 clk = ~clk;

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog: a hung handshake shows up as a long run with no word moving.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("detection_box_decode_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // One score word. Random idle cycles go in front of it; valid stays high
  // after acceptance so back-to-back words need no extra edge.
  task automatic send_score(input logic [15:0] cx, cy, bw, bh, score,
                            input logic last, input logic [15:0] pidx);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_center_x    <= cx;
    in_center_y    <= cy;
    in_box_w       <= bw;
    in_box_h       <= bh;
    in_class_score <= score;
    in_last_class  <= last;
    in_pred_index  <= pidx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Stop sending, let every predicted box come out, then give any dropped
  // prediction time to leave the pipe before registers change.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (boxes_pending != 0) @(posedge clk);
    repeat (IDLE_TAIL) @(posedge clk);
  endtask

  // Full sweep of the register port, with junk above each register's width
  // and the two unused indexes written last so a bad decode would show.
  task automatic write_registers(input logic [12:0] ow, oh, input logic [10:0] px, py,
                                 input logic [23:0] scale, input logic [15:0] thr);
    cfg_we    <= 1'b1;
    cfg_index <= dbd_pkg::CFG_ORIG_WIDTH;
    cfg_data  <= {11'($urandom), ow};
    @(posedge clk);
    cfg_index <= dbd_pkg::CFG_ORIG_HEIGHT;
    cfg_data  <= {11'($urandom), oh};
    @(posedge clk);
    cfg_index <= dbd_pkg::CFG_PAD_X;
    cfg_data  <= {13'($urandom), px};
    @(posedge clk);
    cfg_index <= dbd_pkg::CFG_PAD_Y;
    cfg_data  <= {13'($urandom), py};
    @(posedge clk);
    cfg_index <= dbd_pkg::CFG_INV_SCALE;
    cfg_data  <= scale;
    @(posedge clk);
    cfg_index <= dbd_pkg::CFG_CONF_THRESHOLD;
    cfg_data  <= {8'($urandom), thr};
    @(posedge clk);
    cfg_index <= CFG_UNUSED_LO;
    cfg_data  <= 24'($urandom);
    @(posedge clk);
    cfg_index <= CFG_UNUSED_HI;
    cfg_data  <= 24'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_threshold = thr;
  endtask

  initial begin : stimulus
    logic [12:0] ow, oh;
    logic [10:0] px, py;
    logic [23:0] scale;
    logic [15:0] thr, cx, cy, bw, bh, score;
    int unsigned n, pick, seg_words;
    bit          ramp, shaped, wild;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed words, registers at reset values (640x480, pad 0/80, 1.0x)
    // single class at full score, box well inside the image
    send_score(16'd10240, 16'd10240, 16'd3200, 16'd1600, 16'hFFFF, 1'b1, 16'hFFFF);
    // zero score, zero box: below threshold
    send_score(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 16'd0);
    // score equal to threshold is kept; box past the bottom-right corner
    send_score(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd16384, 1'b1, 16'd1);
    // one below threshold
    send_score(16'd10240, 16'd10240, 16'd3200, 16'd1600, 16'd16383, 1'b1, 16'd2);
    // tie between classes 1 and 2: first wins; box hangs off the left edge
    send_score(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd100, 1'b0, 16'hFFFF);
    send_score(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd30000, 1'b0, 16'hFFFF);
    send_score(16'd0, 16'd10240, 16'd1600, 16'd1600, 16'd30000, 1'b1, 16'd3);
    // strictly greater later score wins; box above the top edge
    send_score(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd20000, 1'b0, 16'hFFFF);
    send_score(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'd10000, 1'b0, 16'h0000);
    send_score(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd50000, 1'b0, 16'hFFFF);
    send_score(16'd10240, 16'd2560, 16'd640, 16'd640, 16'd49999, 1'b1, 16'd4);
    // all scores zero
    send_score(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 1'b0, 16'hFFFF);
    send_score(16'd10240, 16'd10240, 16'd3200, 16'd1600, 16'd0, 1'b1, 16'd5);
    // zero width collapses the box
    send_score(16'd10240, 16'd10240, 16'd0, 16'd1600, 16'hFFFF, 1'b1, 16'd6);
    // right edge overflow trims the width
    send_score(16'd19840, 16'd10240, 16'd3200, 16'd1600, 16'd40000, 1'b1, 16'd7);
    // more classes than the counter holds: rising scores leave the best class
    // on the saturated index
    for (int unsigned k = 0; k < SAT_WORDS; k++) begin
      send_score(16'd10240, 16'd10240, 16'd3200, 16'd1600,
                 16'(k * 200 + $urandom_range(0, 150)), k + 1 == SAT_WORDS, 16'd8);
    end
    settle();

    // --- random segments, one register setting each
    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      if (seg == 4) begin
        send_idle_pct  = 59;
        recv_stall_pct = 9;
      end else if (seg == 8) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end

      case (seg)
        // smallest everything: image size zero saturates to one, sizes vanish
        0: write_registers(13'd0, 13'd1, 11'd0, 11'd0, 24'd1, 16'd0);
        // largest everything: oversize image saturates to 4096
        1: write_registers(13'h1FFF, 13'd4096, 11'h7FF, 11'h7FF, 24'hFFFFFF, 16'hFFFF);
        // zero scale: nothing may come out
        2: write_registers(13'd640, 13'd480, 11'd0, 11'd80, 24'd0, 16'd0);
        3: write_registers(dbd_pkg::RST_ORIG_WIDTH, dbd_pkg::RST_ORIG_HEIGHT,
                           dbd_pkg::RST_PAD_X, dbd_pkg::RST_PAD_Y,
                           dbd_pkg::RST_INV_SCALE, dbd_pkg::RST_CONF_THRESHOLD);
        default: begin
          // mostly realistic letterbox settings, sometimes anything at all
          wild  = ($urandom_range(0, 4) == 0);
          ow    = wild ? 13'($urandom) : 13'($urandom_range(64, 1920));
          oh    = wild ? 13'($urandom) : 13'($urandom_range(64, 1920));
          px    = wild ? 11'($urandom) : 11'($urandom_range(0, 255));
          py    = wild ? 11'($urandom) : 11'($urandom_range(0, 255));
          scale = wild ? 24'($urandom) : 24'($urandom_range(24576, 196608));
          thr   = wild ? 16'($urandom) : 16'($urandom_range(0, 40000));
          write_registers(ow, oh, px, py, scale, thr);
        end
      endcase

      seg_words = 0;
      while (seg_words < SEG_WORDS) begin
        // class count: mostly a handful, now and then a long run to the
        // end of the segment
        pick = $urandom_range(0, 99);
        if (pick < 85)      n = $urandom_range(1, 6);
        else if (pick < 97) n = $urandom_range(7, 24);
        else                n = SEG_WORDS;
        if (n > SEG_WORDS - seg_words) n = SEG_WORDS - seg_words;
        // rising scores move the best class along a long run
        ramp   = (pick >= 97) && ($urandom_range(0, 1) == 1);
        shaped = ($urandom_range(0, 9) != 0);
        for (int unsigned k = 0; k < n; k++) begin
          if (ramp) begin
            score = 16'(k * 200 + $urandom_range(0, 150));
          end else begin
            case ($urandom_range(0, 7))
              0:       score = 16'h0000;
              1:       score = 16'hFFFF;
              2:       score = cur_threshold;
              3:       score = cur_threshold - 16'd1;
              default: score = 16'($urandom);
            endcase
          end
          // box on the last word lies mostly inside the model frame
          if (k + 1 == n && shaped) begin
            cx = 16'($urandom_range(0, 32767));
            cy = 16'($urandom_range(0, 32767));
            bw = 16'($urandom_range(0, 16383));
            bh = 16'($urandom_range(0, 16383));
          end else begin
            cx = 16'($urandom);
            cy = 16'($urandom);
            bw = 16'($urandom);
            bh = 16'($urandom);
          end
          send_score(cx, cy, bw, bh, score, k + 1 == n, 16'($urandom));
          seg_words++;
        end
      end
      settle();
    end

    if (mismatches == 0 && boxes_pending == 0) begin
      $display("detection_box_decode_core: match");
    end else begin
      $display("detection_box_decode_core: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/dbd_pkg.sv
sv/dbd_front.sv
sv/dbd_queue.sv
sv/dbd_back.sv
sv/detection_box_decode_core.sv
sv/dbd_checker.sv
tb/detection_box_decode_checker.sv
tb/detection_box_decode_core_tb.sv
